>>> sv/sbe_pkg.sv
// ----------------------------------------------------------------------------
// sbe_pkg
// shared types of the stack bytecode executor: decoded operations, status
// codes and the queued instruction record
// ----------------------------------------------------------------------------
package sbe_pkg;

  localparam int unsigned XLEN = 64;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_NEG,
    OP_PUSH,
    OP_SAVE,
    OP_GET,
    OP_INC,
    OP_DEC,
    OP_HALT,
    OP_UNDEF
  } op_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDEF = 3'd1,
    ST_TYPE  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_OVER  = 3'd4,
    ST_UNDER = 3'd5,
    ST_HALT  = 3'd6
  } status_e;

  typedef struct packed {
    op_e             op;
    logic [XLEN-1:0] imm;
    logic [7:0]      idx;
    logic            idx_ovf;
  } item_t;

endpackage

>>> sv/sbe_ram.sv
// ----------------------------------------------------------------------------
// sbe_ram
// generic memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
module sbe_ram #(
  parameter int unsigned Width = 65,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr0_i,
  output logic [Width-1:0]         rdata0_o,
  input  logic [$clog2(Depth)-1:0] raddr1_i,
  output logic [Width-1:0]         rdata1_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

>>> sv/sbe_mdu.sv
// ----------------------------------------------------------------------------
// sbe_mdu
// multicycle multiply (three 32x32 partial products) and signed
// restoring divide, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sbe_mdu import sbe_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            div_i,
  input  logic [XLEN-1:0] a_i,
  input  logic [XLEN-1:0] b_i,
  output logic            done_o,
  output logic [XLEN-1:0] res_o
);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} mstate_e;

  mstate_e         state_q, state_d;
  logic [6:0]      step_q, step_d;
  logic            done_q, done_d;
  logic            neg_q, neg_d;
  logic [XLEN-1:0] a_q, a_d, b_q, b_d, acc_q, acc_d, prod_q, prod_d;
  logic [XLEN-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [31:0]     mop_a, mop_b;
  logic [XLEN:0]   rem_sh, diff;

  assign done_o = done_q;
  assign res_o  = acc_q;

  always_comb begin
    mop_a = a_q[31:0];
    mop_b = b_q[31:0];
    case (step_q[1:0])
      2'd1:    mop_b = b_q[63:32];
      2'd2:    mop_a = a_q[63:32];
      default: ;
    endcase
    rem_sh = {rem_q, quo_q[XLEN-1]};
    diff   = rem_sh - {1'b0, b_q};
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    done_d  = done_q;
    neg_d   = neg_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    case (state_q)
      M_IDLE: begin
        if (start_i) begin
          done_d = 1'b0;
          step_d = '0;
          if (div_i) begin
            state_d = M_DIV;
            quo_d   = a_i[XLEN-1] ? -a_i : a_i;
            b_d     = b_i[XLEN-1] ? -b_i : b_i;
            rem_d   = '0;
            neg_d   = a_i[XLEN-1] ^ b_i[XLEN-1];
          end else begin
            state_d = M_MUL;
            a_d     = a_i;
            b_d     = b_i;
          end
        end
      end
      M_MUL: begin
        prod_d = mop_a * mop_b;
        step_d = step_q + 7'd1;
        case (step_q[1:0])
          2'd0: ;
          2'd1: acc_d = prod_q;
          2'd2: acc_d = acc_q + {prod_q[31:0], 32'd0};
          default: begin
            acc_d   = acc_q + {prod_q[31:0], 32'd0};
            done_d  = 1'b1;
            state_d = M_IDLE;
          end
        endcase
      end
      M_DIV: begin
        if (step_q == 7'd64) begin
          acc_d   = neg_q ? -quo_q : quo_q;
          done_d  = 1'b1;
          state_d = M_IDLE;
        end else begin
          step_d = step_q + 7'd1;
          if (!diff[XLEN]) begin
            rem_d = diff[XLEN-1:0];
            quo_d = {quo_q[XLEN-2:0], 1'b1};
          end else begin
            rem_d = rem_sh[XLEN-1:0];
            quo_d = {quo_q[XLEN-2:0], 1'b0};
          end
        end
      end
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

endmodule

>>> sv/sbe_front.sv
// ----------------------------------------------------------------------------
// sbe_front
// accepts instruction transfers, decodes the opcode and queues the record
// in a two-entry queue toward the execute side
// ----------------------------------------------------------------------------
module sbe_front import sbe_pkg::*; #(
  parameter int unsigned StackDepth = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      opcode_i,
  input  logic [XLEN-1:0] immediate_i,
  input  logic [7:0]      local_index_i,
  output logic            head_valid_o,
  output item_t           head_o,
  input  logic            pop_i
);

  localparam logic [7:0] OpcNop  = 8'h00;
  localparam logic [7:0] OpcAdd  = 8'h61;
  localparam logic [7:0] OpcSave = 8'h63;
  localparam logic [7:0] OpcDiv  = 8'h64;
  localparam logic [7:0] OpcGet  = 8'h65;
  localparam logic [7:0] OpcInc  = 8'h66;
  localparam logic [7:0] OpcDec  = 8'h67;
  localparam logic [7:0] OpcHalt = 8'h68;
  localparam logic [7:0] OpcMul  = 8'h6D;
  localparam logic [7:0] OpcNeg  = 8'h6E;
  localparam logic [7:0] OpcPush = 8'h70;
  localparam logic [7:0] OpcSub  = 8'h73;

  item_t      mem_q [2];
  item_t      item;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  always_comb begin
    case (opcode_i)
      OpcNop:  item.op = OP_NOP;
      OpcAdd:  item.op = OP_ADD;
      OpcSub:  item.op = OP_SUB;
      OpcMul:  item.op = OP_MUL;
      OpcDiv:  item.op = OP_DIV;
      OpcNeg:  item.op = OP_NEG;
      OpcPush: item.op = OP_PUSH;
      OpcSave: item.op = OP_SAVE;
      OpcGet:  item.op = OP_GET;
      OpcInc:  item.op = OP_INC;
      OpcDec:  item.op = OP_DEC;
      OpcHalt: item.op = OP_HALT;
      default: item.op = OP_UNDEF;
    endcase
    item.imm     = immediate_i;
    item.idx     = local_index_i;
    item.idx_ovf = (32'(local_index_i) >= 32'(StackDepth));
  end

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

>>> sv/sbe_back.sv
// ----------------------------------------------------------------------------
// sbe_back
// executes queued instructions on the slot memory, owns the local count,
// the clearing sweep and the result register
// ----------------------------------------------------------------------------
module sbe_back import sbe_pkg::*; #(
  parameter int unsigned StackDepth = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  item_t           head_i,
  output logic            pop_o,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [2:0]      status_o,
  output logic [XLEN-1:0] result_value_o,
  output logic            result_is_int_o
);

  localparam int unsigned AW = $clog2(StackDepth);
  localparam int unsigned DW = $clog2(StackDepth + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WAIT} bstate_e;

  bstate_e         state_q, state_d;
  item_t           cur_q, cur_d;
  logic [DW-1:0]   depth_q, depth_d, clr_cnt_q, clr_cnt_d, clr_lim_q, clr_lim_d;
  logic [7:0]      lc_q, lc_d;
  logic            clr_q, clr_d;
  logic            out_valid_q, out_valid_d, out_int_q, out_int_d;
  status_e         out_st_q, out_st_d;
  logic [XLEN-1:0] out_val_q, out_val_d;

  logic            we;
  logic [AW-1:0]   waddr, raddr0, raddr1;
  logic [XLEN:0]   wdata, rdata0, rdata1;
  logic [XLEN-1:0] rv, lv;
  logic            ri, li, ge1, ge2, full, out_free, binop;
  logic [AW-1:0]   top_a, sec_a, push_a, idx_a;
  logic [DW-1:0]   n_used, n_cfg;
  logic            mdu_start, mdu_done;
  logic [XLEN-1:0] mdu_res;
  op_e             rd_op;
  logic [7:0]      rd_idx;

  sbe_ram #(.Width(XLEN + 1), .Depth(StackDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr0_i(raddr0),
    .rdata0_o(rdata0),
    .raddr1_i(raddr1),
    .rdata1_o(rdata1)
  );

  sbe_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mdu_start),
    .div_i  (cur_q.op == OP_DIV),
    .a_i    (lv),
    .b_i    (rv),
    .done_o (mdu_done),
    .res_o  (mdu_res)
  );

  assign rv       = rdata0[XLEN-1:0];
  assign ri       = rdata0[XLEN];
  assign lv       = rdata1[XLEN-1:0];
  assign li       = rdata1[XLEN];
  assign ge1      = (depth_q != '0);
  assign ge2      = (depth_q >= DW'(2));
  assign full     = (depth_q == DW'(StackDepth));
  assign top_a    = AW'(depth_q - DW'(1));
  assign sec_a    = AW'(depth_q - DW'(2));
  assign push_a   = AW'(depth_q);
  assign idx_a    = AW'(cur_q.idx);
  assign out_free = !out_valid_q || !out_stall_i;
  assign n_used   = (32'(lc_q) < 32'(StackDepth)) ? DW'(lc_q) : DW'(StackDepth);
  assign n_cfg    = (32'(cfg_data_i) < 32'(StackDepth)) ? DW'(cfg_data_i)
                                                       : DW'(StackDepth);

  // reads are issued as the record leaves the queue, then held on the
  // current record while it waits for the result register or the mdu
  assign pop_o  = (state_q == S_IDLE) && head_valid_i && !clr_q;
  assign rd_op  = (state_q == S_IDLE) ? head_i.op : cur_q.op;
  assign rd_idx = (state_q == S_IDLE) ? head_i.idx : cur_q.idx;
  assign binop  = (rd_op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV});
  assign raddr0 = AW'(depth_q - DW'(1));
  assign raddr1 = binop ? AW'(depth_q - DW'(2)) : AW'(rd_idx);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    depth_d     = depth_q;
    lc_d        = lc_q;
    clr_d       = clr_q;
    clr_cnt_d   = clr_cnt_q;
    clr_lim_d   = clr_lim_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_st_d    = out_st_q;
    out_val_d   = out_val_q;
    out_int_d   = out_int_q;
    we          = 1'b0;
    waddr       = top_a;
    wdata       = '0;
    mdu_start   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          cur_d   = head_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_st_d    = ST_OK;
          out_val_d   = '0;
          out_int_d   = 1'b0;
          state_d     = S_IDLE;
          case (cur_q.op)
            OP_NOP: ;
            OP_ADD, OP_SUB: begin
              if (!ge2) begin
                out_st_d = ST_UNDER;
              end else begin
                we      = 1'b1;
                waddr   = sec_a;
                depth_d = depth_q - DW'(1);
                if (cur_q.op == OP_SUB) begin
                  wdata = {1'b1, lv - rv};
                end else if (ri && li) begin
                  wdata = {1'b1, lv + rv};
                end else begin
                  out_st_d = ST_TYPE;
                end
              end
            end
            OP_MUL, OP_DIV: begin
              if (!ge2) begin
                out_st_d = ST_UNDER;
              end else if ((cur_q.op == OP_DIV) && (rv == '0)) begin
                we       = 1'b1;
                waddr    = sec_a;
                wdata    = {1'b1, {XLEN{1'b0}}};
                depth_d  = depth_q - DW'(1);
                out_st_d = ST_DIVZ;
              end else begin
                mdu_start   = 1'b1;
                out_valid_d = out_valid_q && out_stall_i;
                state_d     = S_WAIT;
              end
            end
            OP_NEG: begin
              if (!ge1) begin
                out_st_d = ST_UNDER;
              end else if (ri) begin
                we    = 1'b1;
                wdata = {1'b1, -rv};
              end else begin
                out_st_d = ST_TYPE;
              end
            end
            OP_PUSH: begin
              if (full) begin
                out_st_d = ST_OVER;
              end else begin
                we      = 1'b1;
                waddr   = push_a;
                wdata   = {1'b1, cur_q.imm};
                depth_d = depth_q + DW'(1);
              end
            end
            OP_SAVE: begin
              if (cur_q.idx_ovf) begin
                out_st_d = ST_OVER;
              end else if (!ge1) begin
                out_st_d = ST_UNDER;
              end else begin
                we      = 1'b1;
                waddr   = idx_a;
                wdata   = rdata0;
                depth_d = depth_q - DW'(1);
              end
            end
            OP_GET: begin
              if (cur_q.idx_ovf || full) begin
                out_st_d = ST_OVER;
              end else begin
                we      = 1'b1;
                waddr   = push_a;
                wdata   = rdata1;
                depth_d = depth_q + DW'(1);
              end
            end
            OP_INC, OP_DEC: begin
              if (cur_q.idx_ovf) begin
                out_st_d = ST_OVER;
              end else if (!li) begin
                out_st_d = ST_TYPE;
              end else begin
                we    = 1'b1;
                waddr = idx_a;
                wdata = (cur_q.op == OP_INC) ? {1'b1, lv + 64'd1} : {1'b1, lv - 64'd1};
              end
            end
            OP_HALT: begin
              out_st_d = ST_HALT;
              if (depth_q > n_used) begin
                out_val_d = ri ? rv : '0;
                out_int_d = ri;
              end
              depth_d   = n_used;
              clr_d     = (n_used != '0);
              clr_cnt_d = '0;
              clr_lim_d = n_used;
            end
            default: out_st_d = ST_UNDEF;
          endcase
        end
      end
      S_WAIT: begin
        if (mdu_done && out_free) begin
          we          = 1'b1;
          waddr       = sec_a;
          wdata       = {1'b1, mdu_res};
          depth_d     = depth_q - DW'(1);
          out_valid_d = 1'b1;
          out_st_d    = ST_OK;
          out_val_d   = '0;
          out_int_d   = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // clearing sweep owns the write port, no item starts meanwhile
    if (clr_q) begin
      we        = 1'b1;
      waddr     = AW'(clr_cnt_q);
      wdata     = '0;
      clr_cnt_d = clr_cnt_q + DW'(1);
      if (clr_cnt_d == clr_lim_q) begin
        clr_d = 1'b0;
      end
    end

    if (cfg_we_i) begin
      lc_d    = cfg_data_i;
      depth_d = n_cfg;
      if (clr_q) begin
        if (n_cfg > clr_lim_q) begin
          clr_lim_d = n_cfg;
        end
        if (clr_cnt_d == clr_lim_q && n_cfg > clr_lim_q) begin
          clr_d = 1'b1;
        end
      end else if (n_cfg != '0) begin
        clr_d     = 1'b1;
        clr_cnt_d = '0;
        clr_lim_d = n_cfg;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      lc_q        <= '0;
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      clr_lim_q   <= DW'(StackDepth);
      out_valid_q <= 1'b0;
      out_st_q    <= ST_OK;
      out_val_q   <= '0;
      out_int_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      lc_q        <= lc_d;
      clr_q       <= clr_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_lim_q   <= clr_lim_d;
      out_valid_q <= out_valid_d;
      out_st_q    <= out_st_d;
      out_val_q   <= out_val_d;
      out_int_q   <= out_int_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign result_value_o  = out_val_q;
  assign result_is_int_o = out_int_q;

endmodule

>>> sv/stack_bytecode_executor.sv
// ----------------------------------------------------------------------------
// stack_bytecode_executor
// bytecode interpreter on a stack of tagged 64-bit values (integer or nil)
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_stall_o    opcode_i, immediate_i,
//                                                   local_index_i
//   out       output     out_valid_o / out_stall_i  status_o, result_value_o,
//                                                   result_is_int_o
//   cfg       input      cfg_we_i                   cfg_data_i (local count)
//
// an instruction reads the slot memory as it leaves the queue, then does
// the read-modify-write; multiply (three 32x32 partial products) and
// divide (one quotient bit per cycle) first run in the multiply/divide unit
// after reset a clearing sweep of all StackDepth slots runs; halt and a
// local count write sweep the first min(local_count, StackDepth) slots;
// no instruction starts during a sweep
// up to two transfers queue while the execute side or the result waits
// ----------------------------------------------------------------------------
module stack_bytecode_executor import sbe_pkg::*; #(
  parameter int unsigned StackDepth = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             opcode_i,
  input  logic signed [XLEN-1:0] immediate_i,
  input  logic [7:0]             local_index_i,
  input  logic                   cfg_we_i,
  input  logic [7:0]             cfg_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             status_o,
  output logic signed [XLEN-1:0] result_value_o,
  output logic                   result_is_int_o
);

  // decoded record crossing from front to execute side
  item_t           head;
  logic            head_valid, pop;
  logic [XLEN-1:0] res_val;

  sbe_front #(.StackDepth(StackDepth)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .immediate_i  (immediate_i),
    .local_index_i(local_index_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // execute side: slot memory, multiply/divide unit, result register
  sbe_back #(.StackDepth(StackDepth)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .result_value_o (res_val),
    .result_is_int_o(result_is_int_o)
  );

  assign result_value_o = res_val;

`ifndef SYNTH
  // only a halt returns a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_HALT) |-> (result_value_o == '0) && !result_is_int_o)
    else $error("non-halt result carries a value");

  // a nil return reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_is_int_o |-> result_value_o == '0)
    else $error("nil result with nonzero value");

  // a waiting result is not replaced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(result_value_o))
    else $error("stalled result changed");
`endif

endmodule
